>>> design/magic_length_frame_deframer_defines.svh
// assertion helpers for the frame deframer
`ifndef MAGIC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH
`define MAGIC_LENGTH_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MLFD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define MLFD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/mlfd_pkg.sv
package mlfd_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned LenW  = 32;
  localparam int unsigned PosW  = 2;

  // apb register map
  localparam int unsigned AddrW           = 3;
  localparam int unsigned DataW           = 32;
  localparam logic        RegMaxPayload   = 1'b0;
  localparam logic [LenW-1:0] MaxPayloadRst = 32'd4088;

  // frame header magic, one byte per position
  localparam logic [3:0][ByteW-1:0] Magic = {8'h45, 8'h4B, 8'h4F, 8'h50};

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  // one result request from the frame parser
  typedef struct packed {
    logic              valid;
    logic [ByteW-1:0]  payload_byte;
    logic              frame_first;
    logic              frame_last;
    logic              frame_empty;
    logic [LenW-1:0]   frame_length;
  } result_t;

endpackage

>>> design/mlfd_if.sv
interface mlfd_in_if;
  logic                        valid;
  logic                        ready;
  logic [mlfd_pkg::ByteW-1:0]  in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mlfd_out_if;
  logic                        valid;
  logic                        ready;
  logic [mlfd_pkg::ByteW-1:0]  payload_byte;
  logic                        frame_first;
  logic                        frame_last;
  logic                        frame_empty;
  logic [mlfd_pkg::LenW-1:0]   frame_length;

  modport source (output valid, output payload_byte, output frame_first, output frame_last,
                  output frame_empty, output frame_length, input ready);
  modport sink   (input valid, input payload_byte, input frame_first, input frame_last,
                  input frame_empty, input frame_length, output ready);
endinterface

>>> design/mlfd_parser.sv
module mlfd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [mlfd_pkg::ByteW-1:0]  byte_i,
  input  logic [mlfd_pkg::LenW-1:0]   max_payload_i,
  output mlfd_pkg::result_t           result_o
);
  import mlfd_pkg::*;

  phase_e            phase_q, phase_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [LenW-1:0]   len_q, len_d;
  logic [LenW-1:0]   rem_q, rem_d;

  logic [LenW-1:0]   acc;
  logic [PosW-1:0]   hunt_pos;
  logic              rem_last;

  // merge the byte into its little-endian lane of the length
  always_comb begin
    acc = len_q;
    case (pos_q)
      2'd0:    acc[7:0]   = len_q[7:0]   | byte_i;
      2'd1:    acc[15:8]  = len_q[15:8]  | byte_i;
      2'd2:    acc[23:16] = len_q[23:16] | byte_i;
      default: acc[31:24] = len_q[31:24] | byte_i;
    endcase
  end

  // unused phase code hunts from the first magic byte
  assign hunt_pos = (phase_q == PH_HUNT) ? pos_q : '0;
  assign rem_last = (rem_q <= 32'd1);

  // next state
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    len_d   = len_q;
    rem_d   = rem_q;
    unique case (phase_q)
      PH_LEN: begin
        len_d = acc;
        if (pos_q != 2'd3) begin
          pos_d = pos_q + 2'd1;
        end else if (acc > max_payload_i || acc == '0) begin
          phase_d = PH_HUNT;
          pos_d   = '0;
        end else begin
          rem_d   = acc;
          phase_d = PH_DATA;
          pos_d   = '0;
        end
      end
      PH_DATA: begin
        if (rem_last) begin
          rem_d   = '0;
          phase_d = PH_HUNT;
          pos_d   = '0;
        end else begin
          rem_d = rem_q - 32'd1;
        end
      end
      default: begin
        phase_d = PH_HUNT;
        if (byte_i == Magic[hunt_pos]) begin
          if (hunt_pos == 2'd3) begin
            phase_d = PH_LEN;
            pos_d   = '0;
            len_d   = '0;
          end else begin
            pos_d = hunt_pos + 2'd1;
          end
        end else begin
          pos_d = (byte_i == Magic[0]) ? 2'd1 : 2'd0;
        end
      end
    endcase
  end

  // result for the byte at hand
  always_comb begin
    result_o = '0;
    unique case (phase_q)
      PH_LEN: begin
        if (pos_q == 2'd3 && acc == '0) begin
          result_o.valid       = 1'b1;
          result_o.frame_first = 1'b1;
          result_o.frame_last  = 1'b1;
          result_o.frame_empty = 1'b1;
        end
      end
      PH_DATA: begin
        result_o.valid        = 1'b1;
        result_o.payload_byte = byte_i;
        result_o.frame_first  = (rem_q == len_q);
        result_o.frame_last   = rem_last;
        result_o.frame_length = len_q;
      end
      default: result_o = '0;
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      pos_q   <= '0;
      len_q   <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      len_q   <= len_d;
      rem_q   <= rem_d;
    end
  end

endmodule

>>> design/magic_length_frame_deframer.sv
// Byte-stream frame deframer. Bytes arrive on in_i, one request per byte. The block
// hunts for a four-byte magic header word (0x50 0x4F 0x4B 0x45), then reads a
// 32-bit little-endian length. Lengths above max_payload (APB register at
// address 0, reset 4088) are dropped and hunting restarts; otherwise every payload
// byte comes out on out_o with first/last marks and the announced length, and a
// zero-length frame gives one result with first, last and empty set. Throughput is
// one byte per cycle unless out_o.ready holds a result back: each byte passes once
// through an input register, the parser step and the result register that drives
// out_o. in_i.ready stays high unless a result is held back by out_o.ready.
`include "magic_length_frame_deframer_defines.svh"

module magic_length_frame_deframer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mlfd_pkg::AddrW-1:0]  paddr,
  input  logic [mlfd_pkg::DataW-1:0]  pwdata,
  output logic [mlfd_pkg::DataW-1:0]  prdata,
  output logic                        pready,
  mlfd_in_if.sink                     in_i,
  mlfd_out_if.source                  out_o
);
  import mlfd_pkg::*;

  logic [LenW-1:0]   max_payload_q;
  logic              in_valid_q;
  logic [ByteW-1:0]  in_byte_q;
  result_t           res;
  result_t           out_q;
  logic              out_free;
  logic              advance;
  logic              reg_sel;

  // apb register
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == RegMaxPayload);
  assign prdata  = reg_sel ? max_payload_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_payload_q <= MaxPayloadRst;
    end else if (psel && penable && pwrite && reg_sel) begin
      max_payload_q <= pwdata;
    end
  end

  // pipeline handshake
  assign out_free   = !out_q.valid || out_o.ready;
  assign advance    = in_valid_q && (!res.valid || out_free);
  assign in_i.ready = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.in_byte;
    end
  end

  mlfd_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .byte_i        (in_byte_q),
    .max_payload_i (max_payload_q),
    .result_o      (res)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (out_free) begin
      if (advance && res.valid) begin
        out_q <= res;
      end else begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign out_o.valid        = out_q.valid;
  assign out_o.payload_byte = out_q.payload_byte;
  assign out_o.frame_first  = out_q.frame_first;
  assign out_o.frame_last   = out_q.frame_last;
  assign out_o.frame_empty  = out_q.frame_empty;
  assign out_o.frame_length = out_q.frame_length;

  // checks
  `MLFD_ASSERT_IMP(a_empty_frame, out_q.valid && out_q.frame_empty,
    out_q.frame_first && out_q.frame_last && out_q.frame_length == '0
      && out_q.payload_byte == '0,
    "empty frame result malformed")
  `MLFD_ASSERT_NXT(a_in_hold, in_valid_q && !advance,
    in_valid_q && $stable(in_byte_q), "stalled byte lost")
  `MLFD_ASSERT_IMP(a_stall_cause, in_valid_q && !advance,
    res.valid && out_q.valid && !out_o.ready, "input stage stalled without cause")

endmodule
